[rtl/ddms_pkg.sv]
// ----------------------------------------------------------------------------
// ddms_pkg : shared widths and constants for the drive move sequencer
// Field widths, word layouts, command codes and heading constants.
// ----------------------------------------------------------------------------
package ddms_pkg;

  // Field widths
  localparam int CmdW   = 3;
  localparam int PowW   = 16;
  localparam int DistW  = 31;
  localparam int TheadW = 17;
  localparam int StepsW = 32;
  localparam int HeadW  = 15;
  localparam int RampW  = 15;
  localparam int ErrW   = 15;

  // Packed word widths (rounded up to whole bytes); the command rides in tuser
  localparam int InFieldsW  = PowW + DistW + TheadW + 2 * StepsW + HeadW;
  localparam int InDataW    = ((InFieldsW + 7) / 8) * 8;
  localparam int OutFieldsW = 2 * PowW + 4;
  localparam int OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  // Command codes
  localparam logic [CmdW-1:0] CMD_TICK      = 3'd0;
  localparam logic [CmdW-1:0] CMD_DRIVE     = 3'd1;
  localparam logic [CmdW-1:0] CMD_DRIVE_BY  = 3'd2;
  localparam logic [CmdW-1:0] CMD_ROTATE    = 3'd3;
  localparam logic [CmdW-1:0] CMD_ROTATE_TO = 3'd4;
  localparam logic [CmdW-1:0] CMD_STOP      = 3'd5;

  // Headings in 1/64 degree
  localparam int FULL_TURN    = 23040;
  localparam int HALF_TURN    = 11520;
  localparam int QUARTER_TURN = 5760;

  localparam logic [RampW-1:0] RAMP_STEP_RST = 15'd16;

endpackage

[rtl/differential_drive_move_sequencer_core.sv]
// Input register, one pass of logic, result register: a word passes them in order.
// Throughput: one word per cycle while the output does not stall.
// Stalls on the output hold the result register and back up through the input stage.
// Reset (rst_n low, synchronous): mode goes to its initial state, powers, goals and
// origins clear, ramp_step returns to 16, both word stages empty.
// ----------------------------------------------------------------------------
// differential_drive_move_sequencer_core : two-wheel rover move sequencer
// Arms drive / drive-by / spin / spin-to-heading moves, or stops, on command words and
// ramps motor power, checks travel and heading on each tick word.
// ----------------------------------------------------------------------------
module differential_drive_move_sequencer_core
  import ddms_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // config
  input  logic                cfg_wr_en,
  input  logic [RampW-1:0]    cfg_wr_data,   // ramp_step
  // input words
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [CmdW-1:0]     in_tuser,      // command[2:0]
  // power[15:0], distance[46:16], goal_heading[63:47], left_steps[95:64],
  // right_steps[127:96], compass_heading[142:128], pad
  input  logic [InDataW-1:0]  in_tdata,
  // result words
  output logic                out_tvalid,
  input  logic                out_tready,
  // left_power[15:0], right_power[31:16], accepted[32], busy_res[33],
  // ready_res[34], ramping[35], pad
  output logic [OutDataW-1:0] out_tdata
);

  typedef enum logic [2:0] {
    M_INIT, M_IDLE, M_DRIVE, M_DRIVE_BY, M_ROTATE, M_ROTATE_TO
  } mode_t;

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // Move cur toward tgt by stp, clamping at tgt; stp of zero jumps straight there.
  function automatic logic signed [PowW-1:0] step_toward(
    input logic signed [PowW-1:0] cur,
    input logic signed [PowW-1:0] tgt,
    input logic [RampW-1:0]       stp
  );
    logic signed [PowW+1:0] cur_w;
    logic signed [PowW+1:0] tgt_w;
    logic signed [PowW+1:0] stp_w;
    logic signed [PowW+1:0] up;
    logic signed [PowW+1:0] dn;
    logic signed [PowW-1:0] res;
    cur_w = {{2{cur[PowW-1]}}, cur};
    tgt_w = {{2{tgt[PowW-1]}}, tgt};
    stp_w = $signed({3'b000, stp});
    up    = cur_w + stp_w;
    dn    = cur_w - stp_w;
    if (stp == '0) begin
      res = tgt;
    end else if (cur < tgt) begin
      res = (up > tgt_w) ? tgt : up[PowW-1:0];
    end else if (cur > tgt) begin
      res = (dn < tgt_w) ? tgt : dn[PowW-1:0];
    end else begin
      res = cur;
    end
    return res;
  endfunction

  // Signed heading reduced into 0..FULL_TURN-1; offset by three turns, then
  // one subtract picked by parallel threshold compares.
  function automatic logic [HeadW-1:0] wrap_heading(input logic signed [TheadW-1:0] th);
    logic signed [TheadW+1:0] x;
    logic signed [TheadW+1:0] r;
    x = {{2{th[TheadW-1]}}, th} + 19'sd69120;
    if (x >= 19'sd115200) begin
      r = x - 19'sd115200;
    end else if (x >= 19'sd92160) begin
      r = x - 19'sd92160;
    end else if (x >= 19'sd69120) begin
      r = x - 19'sd69120;
    end else if (x >= 19'sd46080) begin
      r = x - 19'sd46080;
    end else if (x >= 19'sd23040) begin
      r = x - 19'sd23040;
    end else begin
      r = x;
    end
    return r[HeadW-1:0];
  endfunction

  localparam logic signed [HeadW+1:0] FullS    = 17'(FULL_TURN);
  localparam logic signed [HeadW+1:0] HalfS    = 17'(HALF_TURN);
  localparam logic signed [ErrW-1:0]  QuarterS = 15'(QUARTER_TURN);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [RampW-1:0]         ramp_step_r;
  logic                     s1_valid_r;
  logic [CmdW-1:0]          s1_cmd_r;
  logic [InDataW-1:0]       s1_data_r;
  logic                     out_valid_r;
  logic [OutDataW-1:0]      out_data_r;

  mode_t                    mode_r,         mode_nxt;
  logic signed [PowW-1:0]   goal_left_r,    goal_left_nxt;
  logic signed [PowW-1:0]   goal_right_r,   goal_right_nxt;
  logic signed [PowW-1:0]   pwr_left_r,     pwr_left_nxt;
  logic signed [PowW-1:0]   pwr_right_r,    pwr_right_nxt;
  logic signed [StepsW-1:0] origin_left_r,  origin_left_nxt;
  logic signed [StepsW-1:0] origin_right_r, origin_right_nxt;
  logic [DistW-1:0]         travel_goal_r,  travel_goal_nxt;
  logic [HeadW-1:0]         heading_goal_r, heading_goal_nxt;
  logic signed [ErrW-1:0]   prior_err_r,    prior_err_nxt;

  // --------------------------------------------------------------------------
  // Word handshake: result register parts the two sides
  // --------------------------------------------------------------------------
  logic s1_adv;
  logic s1_fire;

  assign s1_adv     = !out_valid_r || out_tready;
  assign s1_fire    = s1_valid_r && s1_adv;
  assign in_tready  = !s1_valid_r || s1_adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // --------------------------------------------------------------------------
  // Unpack the registered input word
  // --------------------------------------------------------------------------
  logic [CmdW-1:0]          cmd;
  logic signed [PowW-1:0]   power;
  logic [DistW-1:0]         distance;
  logic signed [TheadW-1:0] thead;
  logic signed [StepsW-1:0] lsteps;
  logic signed [StepsW-1:0] rsteps;
  logic [HeadW-1:0]         compass;

  assign cmd = s1_cmd_r;
  assign {compass, rsteps, lsteps, thead, distance, power} = s1_data_r[InFieldsW-1:0];

  // --------------------------------------------------------------------------
  // Tick datapath
  // --------------------------------------------------------------------------
  logic signed [PowW-1:0]   ramp_left, ramp_right;
  logic signed [StepsW:0]   dl, dr;
  logic [StepsW-1:0]        dl_abs, dr_abs;
  logic                     travel_done;
  logic signed [HeadW+1:0]  te0, te1, te2;
  logic signed [ErrW-1:0]   tick_err;
  logic                     err_cross;
  logic                     err_near;

  assign ramp_left  = step_toward(pwr_left_r,  goal_left_r,  ramp_step_r);
  assign ramp_right = step_toward(pwr_right_r, goal_right_r, ramp_step_r);

  // travelled distance per wheel, exact over the full count range
  assign dl     = {lsteps[StepsW-1], lsteps} - {origin_left_r[StepsW-1], origin_left_r};
  assign dr     = {rsteps[StepsW-1], rsteps} - {origin_right_r[StepsW-1], origin_right_r};
  assign dl_abs = dl[StepsW] ? 32'(-dl) : dl[StepsW-1:0];
  assign dr_abs = dr[StepsW] ? 32'(-dr) : dr[StepsW-1:0];
  assign travel_done = (dl_abs >= {1'b0, travel_goal_r}) && (dr_abs >= {1'b0, travel_goal_r});

  // heading error while turning: wrap strictly above half a turn
  assign te0 = $signed({2'b00, compass}) - $signed({2'b00, heading_goal_r});
  assign te1 = (te0 > HalfS) ? te0 - FullS : te0;
  assign te2 = (te1 < -HalfS) ? te1 + FullS : te1;
  assign tick_err = te2[ErrW-1:0];

  // sign change of the error, both samples within a quarter turn of the goal
  assign err_cross = (tick_err > 0 && prior_err_r <= 0) || (tick_err < 0 && prior_err_r >= 0);
  assign err_near  = (tick_err > -QuarterS) && (tick_err < QuarterS) &&
                     (prior_err_r > -QuarterS) && (prior_err_r < QuarterS);

  // --------------------------------------------------------------------------
  // Rotate-to set-up datapath
  // --------------------------------------------------------------------------
  logic [HeadW-1:0]         goal_h;
  logic signed [HeadW+1:0]  ce0, ce1, ce2;
  logic signed [HeadW+1:0]  cd0, cd1, cd2;
  logic [7:0]               mag;
  logic signed [PowW-1:0]   spin_pwr;
  logic signed [PowW-1:0]   neg_power;

  assign goal_h = wrap_heading(thead);

  // start-up error wraps at or above half a turn
  assign ce0 = $signed({2'b00, compass}) - $signed({2'b00, goal_h});
  assign ce1 = (ce0 >= HalfS) ? ce0 - FullS : ce0;
  assign ce2 = (ce1 < -HalfS) ? ce1 + FullS : ce1;

  // shortest way round
  assign cd0 = $signed({2'b00, goal_h}) - $signed({2'b00, compass});
  assign cd1 = (cd0 > HalfS) ? cd0 - FullS : cd0;
  assign cd2 = (cd1 < -HalfS) ? cd1 + FullS : cd1;

  assign mag      = power[7:0];
  assign spin_pwr = cd2[HeadW+1] ? -$signed({8'h00, mag}) : $signed({8'h00, mag});

  // negation saturates at the most negative power
  assign neg_power = (power == 16'sh8000) ? 16'sh7FFF : -power;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  logic busy;
  logic accepted;
  logic busy_nxt;
  logic ready_nxt;
  logic ramping_nxt;

  assign busy = (mode_r != M_IDLE) && (mode_r != M_INIT);

  always_comb begin
    mode_nxt         = mode_r;
    goal_left_nxt    = goal_left_r;
    goal_right_nxt   = goal_right_r;
    pwr_left_nxt     = pwr_left_r;
    pwr_right_nxt    = pwr_right_r;
    origin_left_nxt  = origin_left_r;
    origin_right_nxt = origin_right_r;
    travel_goal_nxt  = travel_goal_r;
    heading_goal_nxt = heading_goal_r;
    prior_err_nxt    = prior_err_r;
    accepted         = 1'b0;

    case (cmd)
      CMD_TICK: begin
        case (mode_r)
          M_INIT: begin
            mode_nxt = M_IDLE;
          end
          M_DRIVE, M_ROTATE: begin
            pwr_left_nxt  = ramp_left;
            pwr_right_nxt = ramp_right;
          end
          M_DRIVE_BY: begin
            if (travel_done) begin
              mode_nxt       = M_IDLE;
              goal_left_nxt  = '0;
              goal_right_nxt = '0;
              pwr_left_nxt   = '0;
              pwr_right_nxt  = '0;
            end else begin
              pwr_left_nxt  = ramp_left;
              pwr_right_nxt = ramp_right;
            end
          end
          M_ROTATE_TO: begin
            prior_err_nxt = tick_err;
            if (err_cross && err_near) begin
              mode_nxt       = M_IDLE;
              goal_left_nxt  = '0;
              goal_right_nxt = '0;
              pwr_left_nxt   = '0;
              pwr_right_nxt  = '0;
            end else begin
              pwr_left_nxt  = ramp_left;
              pwr_right_nxt = ramp_right;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_DRIVE: begin
        if (power != '0 && !busy) begin
          mode_nxt       = M_DRIVE;
          goal_left_nxt  = power;
          goal_right_nxt = power;
          pwr_left_nxt   = '0;
          pwr_right_nxt  = '0;
          accepted       = 1'b1;
        end
      end
      CMD_DRIVE_BY: begin
        if (power != '0 && !busy) begin
          mode_nxt         = M_DRIVE_BY;
          goal_left_nxt    = power;
          goal_right_nxt   = power;
          pwr_left_nxt     = '0;
          pwr_right_nxt    = '0;
          origin_left_nxt  = lsteps;
          origin_right_nxt = rsteps;
          travel_goal_nxt  = distance;
          accepted         = 1'b1;
        end
      end
      CMD_ROTATE: begin
        if (power != '0 && !busy) begin
          mode_nxt       = M_ROTATE;
          goal_left_nxt  = power;
          goal_right_nxt = neg_power;
          pwr_left_nxt   = '0;
          pwr_right_nxt  = '0;
          accepted       = 1'b1;
        end
      end
      CMD_ROTATE_TO: begin
        // a spin already under way may be replaced
        if (mag != '0 && !(busy && mode_r != M_ROTATE && mode_r != M_ROTATE_TO)) begin
          mode_nxt         = M_ROTATE_TO;
          heading_goal_nxt = goal_h;
          prior_err_nxt    = ce2[ErrW-1:0];
          goal_left_nxt    = spin_pwr;
          goal_right_nxt   = -spin_pwr;
          pwr_left_nxt     = '0;
          pwr_right_nxt    = '0;
          accepted         = 1'b1;
        end
      end
      CMD_STOP: begin
        mode_nxt       = M_IDLE;
        goal_left_nxt  = '0;
        goal_right_nxt = '0;
        pwr_left_nxt   = '0;
        pwr_right_nxt  = '0;
        accepted       = 1'b1;
      end
      default: begin
        // unknown codes leave everything alone
      end
    endcase
  end

  assign busy_nxt    = (mode_nxt != M_IDLE) && (mode_nxt != M_INIT);
  assign ready_nxt   = (mode_nxt != M_INIT);
  assign ramping_nxt = (pwr_left_nxt != goal_left_nxt) || (pwr_right_nxt != goal_right_nxt);

  // --------------------------------------------------------------------------
  // Clocked; payload registers are not reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r    <= RAMP_STEP_RST;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      mode_r         <= M_INIT;
      goal_left_r    <= '0;
      goal_right_r   <= '0;
      pwr_left_r     <= '0;
      pwr_right_r    <= '0;
      origin_left_r  <= '0;
      origin_right_r <= '0;
      travel_goal_r  <= '0;
      heading_goal_r <= '0;
      prior_err_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        ramp_step_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (in_tready && in_tvalid) begin
        s1_cmd_r  <= in_tuser;
        s1_data_r <= in_tdata;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        mode_r         <= mode_nxt;
        goal_left_r    <= goal_left_nxt;
        goal_right_r   <= goal_right_nxt;
        pwr_left_r     <= pwr_left_nxt;
        pwr_right_r    <= pwr_right_nxt;
        origin_left_r  <= origin_left_nxt;
        origin_right_r <= origin_right_nxt;
        travel_goal_r  <= travel_goal_nxt;
        heading_goal_r <= heading_goal_nxt;
        prior_err_r    <= prior_err_nxt;
        out_data_r     <= {(OutDataW - OutFieldsW)'(0), ramping_nxt, ready_nxt, busy_nxt,
                           accepted, pwr_right_nxt, pwr_left_nxt};
      end
    end
  end

endmodule
